[rtl/core/randomness_stats_accumulator_core_macros.svh]
// Assertion macros shared by the accumulator RTL.
// Each macro is empty when NO_ASSERTIONS is defined.
`ifndef RANDOMNESS_STATS_ACCUMULATOR_CORE_MACROS_SVH
`define RANDOMNESS_STATS_ACCUMULATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every edge.
`define RSAC_ASSERT_HOLD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rsac: invariant violated");

// Same-cycle implication.
`define RSAC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsac: same-cycle check violated");

// Next-cycle implication.
`define RSAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsac: next-cycle check violated");

`else

`define RSAC_ASSERT_HOLD(lbl, clk, rst, prop)
`define RSAC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RSAC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/core/rsac_pkg.sv]
`default_nettype none

package rsac_pkg;

   // default parameter values
   localparam int MONTE_BYTES_DEFAULT = 6;
   localparam int COUNT_BITS_DEFAULT  = 32;

   // fixed field widths
   localparam int SYM_W     = 8;
   localparam int BIN_DEPTH = 256;
   localparam int OUT_CNT_W = 32;
   localparam int CROSS_W   = 48;
   localparam int VALUE_W   = 40;
   localparam int SQUARE_W  = 48;

   // request opcodes; the spare code behaves as a read
   typedef logic [1:0] op_type;
   localparam op_type OP_FEED  = 2'd0;
   localparam op_type OP_READ  = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   // one response as it travels down the pipeline
   typedef struct packed {
      logic [OUT_CNT_W-1:0] bin_count;
      logic [OUT_CNT_W-1:0] total_count;
      logic [OUT_CNT_W-1:0] monte_tries;
      logic [OUT_CNT_W-1:0] monte_inside;
      logic [CROSS_W-1:0]   corr_cross_sum;
      logic [VALUE_W-1:0]   corr_sum;
      logic [SQUARE_W-1:0]  corr_square_sum;
      logic [SYM_W-1:0]     first_symbol;
      logic [SYM_W-1:0]     last_symbol;
      logic                 any_seen;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/rsac_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
// A read of the address being written returns the old contents.
module rsac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/randomness_stats_accumulator_core.sv]
// Running-sum accumulator for statistical randomness testing of a byte stream.
//
// Request channel (req_*): op, data_byte, bin_index with valid/stall. A feed
// request adds one byte (one symbol, or eight bit symbols when binary mode is
// set); a read request changes nothing; a clear request zeroes every sum.
// Response channel (rsp_*): one response per request with all sums as they
// stand after that request, including the histogram bin at bin_index.
// CSR port: csr_wr_en/csr_wr_data write binary mode; write it only when idle.
//
// Four-stage pipeline: histogram/symbol stage, sum stage, Monte Carlo compare
// stage, response register. A taken request passes stages A, B and C into the
// response register; one request is taken per clock while req_stall is low.
// The histogram lives in RAM with a per-bin valid flag, so reset and clear take
// effect at once and there is no clearing sweep. A stalled response holds its
// register; stages behind it keep filling bubbles and keep taking requests
// until the pipe is full, then req_stall rises. Reset clears all sums, the
// histogram and binary mode, and empties the pipeline.
`default_nettype none

`include "randomness_stats_accumulator_core_macros.svh"

module randomness_stats_accumulator_core #(
   parameter int MONTE_BYTES = rsac_pkg::MONTE_BYTES_DEFAULT,
   parameter int COUNT_BITS  = rsac_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [7:0]  req_bin_index,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_bin_count,
   output logic [31:0]      rsp_total_count,
   output logic [31:0]      rsp_monte_tries,
   output logic [31:0]      rsp_monte_inside,
   output logic [47:0]      rsp_corr_cross_sum,
   output logic [39:0]      rsp_corr_sum,
   output logic [47:0]      rsp_corr_square_sum,
   output logic [7:0]       rsp_first_symbol,
   output logic [7:0]       rsp_last_symbol,
   output logic             rsp_any_seen
);

   localparam int SYM_W    = rsac_pkg::SYM_W;
   localparam int OUT_W    = rsac_pkg::OUT_CNT_W;
   localparam int CROSS_W  = rsac_pkg::CROSS_W;
   localparam int VALUE_W  = rsac_pkg::VALUE_W;
   localparam int SQUARE_W = rsac_pkg::SQUARE_W;
   localparam int CNT_W    = (COUNT_BITS < OUT_W) ? COUNT_BITS : OUT_W;
   localparam int PROD_W   = 2 * SYM_W;
   localparam int STEP_W   = $clog2(SYM_W + 1);
   localparam int HALF     = MONTE_BYTES / 2;
   localparam int XY_W     = SYM_W * HALF;
   localparam int SQ_W     = 2 * XY_W;
   localparam int POS_W    = $clog2(MONTE_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MONTE_BYTES - 1);
   localparam logic [SQ_W-1:0]  R_MAX    = SQ_W'({XY_W{1'b1}});
   localparam logic [SQ_W-1:0]  R_SQ     = R_MAX * R_MAX;
   localparam logic [SYM_W-1:0] BIN_ZERO = SYM_W'(0);
   localparam logic [SYM_W-1:0] BIN_ONE  = SYM_W'(1);

   // saturating counter add
   function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] base,
                                                input logic [STEP_W-1:0] step);
      logic [CNT_W:0] sum;
      sum = {1'b0, base} + (CNT_W+1)'(step);
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

   // ---------------------------------------------------------------- flow
   logic out_free, c_free, b_free, a_free;
   logic req_accept, a_fire, b_fire, c_fire;
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      c_free     = !c_valid_ff || out_free;
      b_free     = !b_valid_ff || c_free;
      a_free     = !a_valid_ff || b_free;
      req_accept = req_valid && a_free;
      a_fire     = a_valid_ff && b_free;
      b_fire     = b_valid_ff && c_free;
      c_fire     = c_valid_ff && out_free;
   end

   assign req_stall = !a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= req_valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_free) begin
            c_valid_ff <= b_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= c_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------- config
   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- stage A
   logic [1:0]       a_op_ff;
   logic [SYM_W-1:0] a_byte_ff;
   logic [SYM_W-1:0] a_bin_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_op_ff   <= req_op;
         a_byte_ff <= req_data_byte;
         a_bin_ff  <= req_bin_index;
      end
   end

   // opcode decode
   logic feed_a, clr_a;

   always_comb begin
      feed_a = 1'b0;
      clr_a  = 1'b0;
      case (a_op_ff)
         rsac_pkg::OP_FEED: begin
            feed_a = a_valid_ff;
         end
         rsac_pkg::OP_CLEAR: begin
            clr_a = a_valid_ff;
         end
         rsac_pkg::OP_READ: begin
            feed_a = 1'b0;
         end
         default: begin
            feed_a = 1'b0;
         end
      endcase
   end

   // histogram: bins 0 and 1 in flops, the rest in RAM with valid flags
   logic [CNT_W-1:0]              bin0_ff, bin1_ff, bin0_in, bin1_in;
   logic [rsac_pkg::BIN_DEPTH-1:0] hist_vld_ff;
   logic                          bp_en_ff;
   logic [SYM_W-1:0]              bp_addr_ff;
   logic [CNT_W-1:0]              bp_data_ff;
   logic [CNT_W-1:0]              ram_sym_data, ram_idx_data;
   logic [SYM_W-1:0]              rd_sym_addr, rd_idx_addr;
   logic [CNT_W-1:0]              sym_val, idx_val, sym_inc, bin_val;
   logic                          hist_wr, hist_wr_en;
   logic [STEP_W-1:0]             ones, zeros;

   assign rd_sym_addr = a_free ? req_data_byte : a_byte_ff;
   assign rd_idx_addr = a_free ? req_bin_index : a_bin_ff;

   rsac_ram #(
      .WIDTH (CNT_W),
      .DEPTH (rsac_pkg::BIN_DEPTH)
   ) u_hist_sym (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (a_byte_ff),
      .wr_data (sym_inc),
      .rd_addr (rd_sym_addr),
      .rd_data (ram_sym_data)
   );

   rsac_ram #(
      .WIDTH (CNT_W),
      .DEPTH (rsac_pkg::BIN_DEPTH)
   ) u_hist_idx (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (a_byte_ff),
      .wr_data (sym_inc),
      .rd_addr (rd_idx_addr),
      .rd_data (ram_idx_data)
   );

   // read data with last-write bypass and cleared-bin masking
   always_comb begin
      if (bp_en_ff && (bp_addr_ff == a_byte_ff)) begin
         sym_val = bp_data_ff;
      end else if (hist_vld_ff[a_byte_ff]) begin
         sym_val = ram_sym_data;
      end else begin
         sym_val = '0;
      end
      if (bp_en_ff && (bp_addr_ff == a_bin_ff)) begin
         idx_val = bp_data_ff;
      end else if (hist_vld_ff[a_bin_ff]) begin
         idx_val = ram_idx_data;
      end else begin
         idx_val = '0;
      end
   end

   always_comb begin
      ones    = STEP_W'($countones(a_byte_ff));
      zeros   = STEP_W'(SYM_W) - ones;
      sym_inc = sat_cnt(sym_val, STEP_W'(1));
      bin0_in = bin0_ff;
      bin1_in = bin1_ff;
      hist_wr = 1'b0;
      if (clr_a) begin
         bin0_in = '0;
         bin1_in = '0;
      end else if (feed_a) begin
         if (mode_ff) begin
            bin0_in = sat_cnt(bin0_ff, zeros);
            bin1_in = sat_cnt(bin1_ff, ones);
         end else if (a_byte_ff == BIN_ZERO) begin
            bin0_in = sat_cnt(bin0_ff, STEP_W'(1));
         end else if (a_byte_ff == BIN_ONE) begin
            bin1_in = sat_cnt(bin1_ff, STEP_W'(1));
         end else begin
            hist_wr = 1'b1;
         end
      end
      hist_wr_en = a_fire && hist_wr;

      // addressed bin after this request
      if (clr_a) begin
         bin_val = '0;
      end else if (a_bin_ff == BIN_ZERO) begin
         bin_val = bin0_in;
      end else if (a_bin_ff == BIN_ONE) begin
         bin_val = bin1_in;
      end else if (hist_wr && (a_bin_ff == a_byte_ff)) begin
         bin_val = sym_inc;
      end else begin
         bin_val = idx_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin0_ff     <= '0;
         bin1_ff     <= '0;
         hist_vld_ff <= '0;
         bp_en_ff    <= 1'b0;
      end else begin
         bp_en_ff <= hist_wr_en;
         if (a_fire) begin
            bin0_ff <= bin0_in;
            bin1_ff <= bin1_in;
            if (clr_a) begin
               hist_vld_ff <= '0;
            end else if (hist_wr) begin
               hist_vld_ff[a_byte_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      bp_addr_ff <= a_byte_ff;
      bp_data_ff <= sym_inc;
   end

   // symbol totals and serial-correlation deltas
   logic [CNT_W-1:0]  total_ff, total_in, tries_ff, tries_in;
   logic              seen_ff, seen_in;
   logic [SYM_W-1:0]  first_ff, first_in, prev_ff, prev_in;
   logic [PROD_W-1:0] cross_d, sq_d;
   logic [SYM_W-1:0]  sum_d;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              mc_done;

   always_comb begin
      mc_done = feed_a && (pos_ff == POS_LAST);

      if (mode_ff) begin
         cross_d = ((seen_ff && a_byte_ff[SYM_W-1]) ? PROD_W'(prev_ff) : '0)
                 + PROD_W'($countones(a_byte_ff[SYM_W-1:1] & a_byte_ff[SYM_W-2:0]));
         sum_d   = SYM_W'(ones);
         sq_d    = PROD_W'(ones);
      end else begin
         cross_d = seen_ff ? (PROD_W'(prev_ff) * PROD_W'(a_byte_ff)) : '0;
         sum_d   = a_byte_ff;
         sq_d    = PROD_W'(a_byte_ff) * PROD_W'(a_byte_ff);
      end

      total_in = total_ff;
      tries_in = tries_ff;
      seen_in  = seen_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      if (clr_a) begin
         total_in = '0;
         tries_in = '0;
         seen_in  = 1'b0;
         first_in = '0;
         prev_in  = '0;
         pos_in   = '0;
      end else if (feed_a) begin
         total_in = sat_cnt(total_ff, mode_ff ? STEP_W'(SYM_W) : STEP_W'(1));
         seen_in  = 1'b1;
         if (!seen_ff) begin
            first_in = mode_ff ? SYM_W'(a_byte_ff[SYM_W-1]) : a_byte_ff;
         end
         prev_in = mode_ff ? SYM_W'(a_byte_ff[0]) : a_byte_ff;
         if (mc_done) begin
            tries_in = sat_cnt(tries_ff, STEP_W'(1));
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         tries_ff <= '0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         prev_ff  <= '0;
         pos_ff   <= '0;
      end else if (a_fire) begin
         total_ff <= total_in;
         tries_ff <= tries_in;
         seen_ff  <= seen_in;
         first_ff <= first_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
      end
   end

   // Monte Carlo group collection; the closing byte is taken straight from stage A
   logic [SYM_W-1:0] group_ff [MONTE_BYTES-1];
   logic [XY_W-1:0]  x_a, y_a;

   for (genvar g = 0; g < MONTE_BYTES - 1; g++) begin : g_group
      always_ff @(posedge clock) begin
         if (a_fire && feed_a && (pos_ff == POS_W'(g))) begin
            group_ff[g] <= a_byte_ff;
         end
      end
   end

   for (genvar i = 0; i < HALF; i++) begin : g_xy
      assign x_a[(HALF-1-i)*SYM_W +: SYM_W] = group_ff[i];
      if (HALF + i < MONTE_BYTES - 1) begin : g_ystore
         assign y_a[(HALF-1-i)*SYM_W +: SYM_W] = group_ff[HALF+i];
      end else begin : g_ylast
         assign y_a[(HALF-1-i)*SYM_W +: SYM_W] = a_byte_ff;
      end
   end

   // snapshot of stage A results
   rsac_pkg::result_type a_res;

   always_comb begin
      a_res              = '0;
      a_res.bin_count    = OUT_W'(bin_val);
      a_res.total_count  = OUT_W'(total_in);
      a_res.monte_tries  = OUT_W'(tries_in);
      a_res.first_symbol = first_in;
      a_res.last_symbol  = prev_in;
      a_res.any_seen     = seen_in;
   end

   // ---------------------------------------------------------------- stage B
   logic                 b_feed_ff, b_clr_ff, b_mc_ff;
   logic [PROD_W-1:0]    b_cross_d_ff, b_sq_d_ff;
   logic [SYM_W-1:0]     b_sum_d_ff;
   logic [XY_W-1:0]      b_x_ff, b_y_ff;
   rsac_pkg::result_type b_res_ff;

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_feed_ff    <= feed_a;
         b_clr_ff     <= clr_a;
         b_mc_ff      <= mc_done;
         b_cross_d_ff <= cross_d;
         b_sum_d_ff   <= sum_d;
         b_sq_d_ff    <= sq_d;
         b_x_ff       <= x_a;
         b_y_ff       <= y_a;
         b_res_ff     <= a_res;
      end
   end

   // saturating correlation sums
   logic [CROSS_W-1:0]  cross_ff, cross_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [SQUARE_W-1:0] square_ff, square_in;
   logic [CROSS_W:0]    cross_sum;
   logic [VALUE_W:0]    value_sum;
   logic [SQUARE_W:0]   square_sum;
   logic [SQ_W-1:0]     sq_x, sq_y;
   rsac_pkg::result_type b_res;

   always_comb begin
      cross_sum  = {1'b0, cross_ff} + (CROSS_W+1)'(b_cross_d_ff);
      value_sum  = {1'b0, value_ff} + (VALUE_W+1)'(b_sum_d_ff);
      square_sum = {1'b0, square_ff} + (SQUARE_W+1)'(b_sq_d_ff);
      cross_in   = cross_ff;
      value_in   = value_ff;
      square_in  = square_ff;
      if (b_clr_ff) begin
         cross_in  = '0;
         value_in  = '0;
         square_in = '0;
      end else if (b_feed_ff) begin
         cross_in  = cross_sum[CROSS_W]   ? {CROSS_W{1'b1}}  : cross_sum[CROSS_W-1:0];
         value_in  = value_sum[VALUE_W]   ? {VALUE_W{1'b1}}  : value_sum[VALUE_W-1:0];
         square_in = square_sum[SQUARE_W] ? {SQUARE_W{1'b1}} : square_sum[SQUARE_W-1:0];
      end

      b_res                 = b_res_ff;
      b_res.corr_cross_sum  = cross_in;
      b_res.corr_sum        = value_in;
      b_res.corr_square_sum = square_in;

      // point coordinates squared
      sq_x = SQ_W'(b_x_ff) * SQ_W'(b_x_ff);
      sq_y = SQ_W'(b_y_ff) * SQ_W'(b_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_ff  <= '0;
         value_ff  <= '0;
         square_ff <= '0;
      end else if (b_fire) begin
         cross_ff  <= cross_in;
         value_ff  <= value_in;
         square_ff <= square_in;
      end
   end

   // ---------------------------------------------------------------- stage C
   logic                 c_feed_ff, c_clr_ff, c_mc_ff;
   logic [SQ_W-1:0]      c_sq_x_ff, c_sq_y_ff;
   rsac_pkg::result_type c_res_ff;

   always_ff @(posedge clock) begin
      if (b_fire) begin
         c_feed_ff <= b_feed_ff;
         c_clr_ff  <= b_clr_ff;
         c_mc_ff   <= b_mc_ff;
         c_sq_x_ff <= sq_x;
         c_sq_y_ff <= sq_y;
         c_res_ff  <= b_res;
      end
   end

   // in-circle test and hit counter
   logic [CNT_W-1:0]     inside_ff, inside_in, inside_inc;
   logic [SQ_W:0]        dist_sq;
   logic                 in_circle;
   rsac_pkg::result_type c_res;

   always_comb begin
      dist_sq    = {1'b0, c_sq_x_ff} + {1'b0, c_sq_y_ff};
      in_circle  = dist_sq <= {1'b0, R_SQ};
      inside_inc = (&inside_ff) ? inside_ff : inside_ff + CNT_W'(1);
      inside_in  = inside_ff;
      if (c_clr_ff) begin
         inside_in = '0;
      end else if (c_feed_ff && c_mc_ff && in_circle) begin
         inside_in = inside_inc;
      end
      c_res              = c_res_ff;
      c_res.monte_inside = OUT_W'(inside_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= '0;
      end else if (c_fire) begin
         inside_ff <= inside_in;
      end
   end

   // ---------------------------------------------------------------- response
   rsac_pkg::result_type rsp_res_ff;

   always_ff @(posedge clock) begin
      if (c_fire) begin
         rsp_res_ff <= c_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_count       = rsp_res_ff.bin_count;
   assign rsp_total_count     = rsp_res_ff.total_count;
   assign rsp_monte_tries     = rsp_res_ff.monte_tries;
   assign rsp_monte_inside    = rsp_res_ff.monte_inside;
   assign rsp_corr_cross_sum  = rsp_res_ff.corr_cross_sum;
   assign rsp_corr_sum        = rsp_res_ff.corr_sum;
   assign rsp_corr_square_sum = rsp_res_ff.corr_square_sum;
   assign rsp_first_symbol    = rsp_res_ff.first_symbol;
   assign rsp_last_symbol     = rsp_res_ff.last_symbol;
   assign rsp_any_seen        = rsp_res_ff.any_seen;

   // ---------------------------------------------------------------- checks
   // an empty first stage always takes a request
   `RSAC_ASSERT_IMPL(a_empty_takes_req, clock, reset, !a_valid_ff, !req_stall)
   // a blocked first stage keeps its request
   `RSAC_ASSERT_NEXT(a_blocked_holds, clock, reset, a_valid_ff && !b_free, a_valid_ff && $stable(a_byte_ff))
   // no symbol since clear means empty sums
   `RSAC_ASSERT_IMPL(unseen_sums_zero, clock, reset, rsp_valid && !rsp_any_seen, rsp_total_count == 0 && rsp_corr_sum == 0 && rsp_corr_cross_sum == 0)
   // hits never outrun tries
   `RSAC_ASSERT_IMPL(inside_le_tries, clock, reset, rsp_valid, rsp_monte_inside <= rsp_monte_tries)
   // sum of squares bounds the plain sum
   `RSAC_ASSERT_HOLD(square_ge_sum, clock, reset, !rsp_valid || (rsp_corr_square_sum >= rsp_corr_sum))

endmodule

`default_nettype wire
